// File: sv/abu_pkg.sv
package abu_pkg;

   localparam logic [7:0] ChMax = 8'd255;

   typedef logic [7:0] chan_type;

   // red in the top byte, alpha in the bottom byte
   typedef struct packed {
      chan_type red;
      chan_type green;
      chan_type blue;
      chan_type alpha;
   } pixel_type;

   // same pixel seen as four byte lanes, lane 0 is alpha
   typedef logic [3:0][7:0] quad_type;

   typedef enum logic [1:0] {
      MODE_UNDER  = 2'd0,
      MODE_OVER   = 2'd1,
      MODE_ADD    = 2'd2,
      MODE_FACTOR = 2'd3
   } mode_type;

   localparam logic CSR_BLEND_MODE = 1'b0;
   localparam logic CSR_ADD_FACTOR = 1'b1;

   // per-pixel operation after early-exit checks
   typedef enum logic [5:0] {
      KIND_DST    = 6'b000001,
      KIND_SRC    = 6'b000010,
      KIND_UNDER  = 6'b000100,
      KIND_OVER   = 6'b001000,
      KIND_ADD    = 6'b010000,
      KIND_FACTOR = 6'b100000
   } kind_type;

   typedef struct packed {
      pixel_type dst;
      pixel_type src;
      kind_type  kind;
      chan_type  mix;
   } stage_type;

   // truncating divide by 255, exact for x up to 255*255
   function automatic chan_type div255(input logic [15:0] x);
      logic [16:0] t;
      t = {1'b0, x} + 17'd1 + {9'd0, x[15:8]};
      return t[15:8];
   endfunction

   // final add and clamp for one byte lane
   function automatic chan_type blend_lane(input kind_type kind, input chan_type d,
                                          input chan_type s, input logic [15:0] prod,
                                          input logic is_alpha);
      logic [8:0] sum;
      logic [8:0] q;
      q = {1'b0, div255(prod)};
      sum = {1'b0, d} + {1'b0, s};
      case (kind)
         KIND_DST:    sum = {1'b0, d};
         KIND_SRC:    sum = {1'b0, s};
         KIND_UNDER:  sum = {1'b0, d} + q;
         KIND_OVER:   sum = q + {1'b0, s};
         KIND_FACTOR: sum = is_alpha ? ({1'b0, d} + {1'b0, s}) : (q + {1'b0, s});
         KIND_ADD:    sum = {1'b0, d} + {1'b0, s};
         default:     sum = {1'b0, d};
      endcase
      return sum[8] ? ChMax : sum[7:0];
   endfunction

endpackage

// File: sv/abu_if.sv
interface abu_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] dst_red;
   logic [7:0] dst_green;
   logic [7:0] dst_blue;
   logic [7:0] dst_alpha;
   logic [7:0] src_red;
   logic [7:0] src_green;
   logic [7:0] src_blue;
   logic [7:0] src_alpha;

   modport source (output valid, dst_red, dst_green, dst_blue, dst_alpha,
                   src_red, src_green, src_blue, src_alpha, input ready);
   modport sink   (input valid, dst_red, dst_green, dst_blue, dst_alpha,
                   src_red, src_green, src_blue, src_alpha, output ready);
endinterface

interface abu_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_red;
   logic [7:0] out_green;
   logic [7:0] out_blue;
   logic [7:0] out_alpha;

   modport source (output valid, out_red, out_green, out_blue, out_alpha, input ready);
   modport sink   (input valid, out_red, out_green, out_blue, out_alpha, output ready);
endinterface

// File: sv/abu_front.sv
module abu_front import abu_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  logic      in_valid,
   output logic      in_ready,
   input  pixel_type in_dst,
   input  pixel_type in_src,
   input  mode_type  blend_mode,
   input  chan_type  add_factor,
   output logic      out_valid,
   input  logic      out_ready,
   output stage_type out_stage
);

   logic        v1_ff, v2_ff;
   logic        adv1, adv2;
   stage_type   s1_ff, s1_in;
   stage_type   s2_ff, s2_in;
   logic [15:0] prod_ff, prod_in;

   // stage advance chain
   assign adv2     = !v2_ff || out_ready;
   assign adv1     = !v1_ff || adv2;
   assign in_ready = adv1;

   // stage 1: early-exit checks and mix for the fixed modes
   always_comb begin
      s1_in.dst  = in_dst;
      s1_in.src  = in_src;
      s1_in.kind = KIND_DST;
      s1_in.mix  = ChMax - in_dst.alpha;
      case (blend_mode)
         MODE_UNDER: begin
            s1_in.mix = ChMax - in_dst.alpha;
            if (in_dst.alpha == ChMax) s1_in.kind = KIND_DST;
            else if (in_dst.alpha == 8'd0) s1_in.kind = KIND_SRC;
            else s1_in.kind = KIND_UNDER;
         end
         MODE_OVER: begin
            s1_in.mix = ChMax - in_src.alpha;
            if (in_src.alpha == 8'd0) s1_in.kind = KIND_DST;
            else if (in_src.alpha == ChMax) s1_in.kind = KIND_SRC;
            else s1_in.kind = KIND_OVER;
         end
         MODE_ADD: begin
            if (in_dst.alpha == 8'd0 || in_src.alpha == ChMax) s1_in.kind = KIND_SRC;
            else s1_in.kind = KIND_ADD;
         end
         MODE_FACTOR: begin
            if (in_dst.alpha == 8'd0) s1_in.kind = KIND_SRC;
            else s1_in.kind = KIND_FACTOR;
         end
         default: s1_in.kind = KIND_DST;
      endcase
   end

   // weighted source alpha for the factor mode
   assign prod_in = {8'd0, in_src.alpha} * {8'd0, ChMax - add_factor};

   // stage 2: factor-mode mix from the weighted alpha
   always_comb begin
      s2_in = s1_ff;
      if (s1_ff.kind == KIND_FACTOR) begin
         s2_in.mix = ChMax - div255(prod_ff);
      end
   end

   // valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else begin
         if (adv1) v1_ff <= in_valid;
         if (adv2) v2_ff <= v1_ff;
      end
   end

   // payload
   always_ff @(posedge clock) begin
      if (adv1) begin
         s1_ff   <= s1_in;
         prod_ff <= prod_in;
      end
      if (adv2) s2_ff <= s2_in;
   end

   assign out_valid = v2_ff;
   assign out_stage = s2_ff;

endmodule

// File: sv/abu_lanes.sv
module abu_lanes import abu_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  logic      in_valid,
   output logic      in_ready,
   input  stage_type in_stage,
   output logic      out_valid,
   input  logic      out_ready,
   output pixel_type out_pixel
);

   logic                  v3_ff, v4_ff;
   logic                  adv3, adv4;
   stage_type             s3_ff;
   logic [3:0][15:0]      prod_ff, prod_in;
   quad_type              dq_in, sq_in, dq, sq, res_in;
   pixel_type             pix_ff;

   assign adv4     = !v4_ff || out_ready;
   assign adv3     = !v3_ff || adv4;
   assign in_ready = adv3;

   assign dq_in = quad_type'(in_stage.dst);
   assign sq_in = quad_type'(in_stage.src);
   assign dq    = quad_type'(s3_ff.dst);
   assign sq    = quad_type'(s3_ff.src);

   for (genvar i = 0; i < 4; i++) begin : g_lane
      // stage 3: mix times source (under) or destination (other modes)
      assign prod_in[i] = {8'd0, in_stage.mix} *
                          {8'd0, (in_stage.kind == KIND_UNDER) ? sq_in[i] : dq_in[i]};
      // stage 4: divide, add, clamp
      assign res_in[i] = blend_lane(s3_ff.kind, dq[i], sq[i], prod_ff[i], i == 0);
   end

   // valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else begin
         if (adv3) v3_ff <= in_valid;
         if (adv4) v4_ff <= v3_ff;
      end
   end

   // payload
   always_ff @(posedge clock) begin
      if (adv3) begin
         s3_ff   <= in_stage;
         prod_ff <= prod_in;
      end
      if (adv4) pix_ff <= pixel_type'(res_in);
   end

   assign out_valid = v4_ff;
   assign out_pixel = pix_ff;

endmodule

// File: sv/rgba_alpha_blend_unit.sv
// four register stages between request accept and result valid
// throughput: one pixel per cycle; each stage advances when the next one is empty or moving
// the output register lets a new request in while a finished result waits
// reset (synchronous, active high) empties the pipeline and sets blend mode to over,
// add factor to zero
module rgba_alpha_blend_unit import abu_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   abu_req_if.sink    req_ch,
   abu_rsp_if.source  rsp_ch,
   input  logic       csr_we,
   input  logic       csr_index,
   input  logic [7:0] csr_wdata
);

   mode_type  blend_mode_ff;
   chan_type  add_factor_ff;
   pixel_type dst, src, res;
   stage_type mid_stage;
   logic      mid_valid, mid_ready;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         blend_mode_ff <= MODE_OVER;
         add_factor_ff <= 8'd0;
      end else if (csr_we) begin
         case (csr_index)
            CSR_BLEND_MODE: blend_mode_ff <= mode_type'(csr_wdata[1:0]);
            CSR_ADD_FACTOR: add_factor_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   assign dst = '{red: req_ch.dst_red, green: req_ch.dst_green,
                  blue: req_ch.dst_blue, alpha: req_ch.dst_alpha};
   assign src = '{red: req_ch.src_red, green: req_ch.src_green,
                  blue: req_ch.src_blue, alpha: req_ch.src_alpha};

   abu_front u_front (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (req_ch.valid),
      .in_ready   (req_ch.ready),
      .in_dst     (dst),
      .in_src     (src),
      .blend_mode (blend_mode_ff),
      .add_factor (add_factor_ff),
      .out_valid  (mid_valid),
      .out_ready  (mid_ready),
      .out_stage  (mid_stage)
   );

   abu_lanes u_lanes (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (mid_valid),
      .in_ready  (mid_ready),
      .in_stage  (mid_stage),
      .out_valid (rsp_ch.valid),
      .out_ready (rsp_ch.ready),
      .out_pixel (res)
   );

   assign rsp_ch.out_red   = res.red;
   assign rsp_ch.out_green = res.green;
   assign rsp_ch.out_blue  = res.blue;
   assign rsp_ch.out_alpha = res.alpha;

endmodule

// File: test/testbench.sv
`timescale 1ns / 100ps

module testbench;
   import abu_pkg::*;

   localparam int CYCLE_LIMIT = 200000;
   localparam int PIPE_DEPTH  = 4;

   logic       clock = 1'b0;
   logic       reset;
   logic       csr_we;
   logic       csr_index;
   logic [7:0] csr_wdata;

   abu_req_if req_ch();
   abu_rsp_if rsp_ch();

   rgba_alpha_blend_unit dut (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch),
      .rsp_ch    (rsp_ch),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // blend settings as the block should hold them
   mode_type  blend_mode_now = MODE_OVER;
   chan_type  factor_now     = '0;

   pixel_type pending_pixels[$];
   int        error_count   = 0;
   int        cycle_count   = 0;
   int        send_idle_pct = 0;
   int        stall_pct     = 0;
   int        stall_hold    = 0;

   always #2 clock = ~clock;

   function automatic chan_type clamp8(int unsigned v);
      return (v > ChMax) ? ChMax : chan_type'(v);
   endfunction

   // expected blended pixel for the current mode and factor
   function automatic pixel_type blend_pixel(pixel_type dst, pixel_type src);
      quad_type    d;
      quad_type    s;
      quad_type    r;
      int unsigned m;
      d = dst;
      s = src;
      r = d;
      case (blend_mode_now)
         MODE_UNDER: begin
            if (dst.alpha == 8'd0) begin
               r = s;
            end else if (dst.alpha != ChMax) begin
               m = ChMax - dst.alpha;
               for (int i = 0; i < 4; i++) r[i] = clamp8(d[i] + m * s[i] / ChMax);
            end
         end
         MODE_OVER: begin
            if (src.alpha == ChMax) begin
               r = s;
            end else if (src.alpha != 8'd0) begin
               m = ChMax - src.alpha;
               for (int i = 0; i < 4; i++) r[i] = clamp8(m * d[i] / ChMax + s[i]);
            end
         end
         MODE_ADD: begin
            if (dst.alpha == 8'd0 || src.alpha == ChMax) begin
               r = s;
            end else begin
               for (int i = 0; i < 4; i++) r[i] = clamp8(int'(d[i]) + int'(s[i]));
            end
         end
         MODE_FACTOR: begin
            if (dst.alpha == 8'd0) begin
               r = s;
            end else begin
               m = ChMax - src.alpha * (ChMax - factor_now) / ChMax;
               // lane 0 is alpha, which adds without the weight
               for (int i = 1; i < 4; i++) r[i] = clamp8(m * d[i] / ChMax + s[i]);
               r[0] = clamp8(int'(d[0]) + int'(s[0]));
            end
         end
      endcase
      return pixel_type'(r);
   endfunction

   // alpha biased toward the early-exit values
   function automatic chan_type pick_alpha();
      case ($urandom_range(0, 3))
         0:       return 8'd0;
         1:       return ChMax;
         default: return chan_type'($urandom_range(0, 255));
      endcase
   endfunction

   // mostly premultiplied pixels, some with any channel values
   function automatic pixel_type random_pixel();
      pixel_type p;
      p = pixel_type'($urandom);
      p.alpha = pick_alpha();
      if ($urandom_range(0, 3) != 0) begin
         p.red   = chan_type'($urandom_range(0, p.alpha));
         p.green = chan_type'($urandom_range(0, p.alpha));
         p.blue  = chan_type'($urandom_range(0, p.alpha));
      end
      return p;
   endfunction

   // offer one request and wait until it is taken
   task automatic send_pixel(input pixel_type dst, input pixel_type src);
      @(negedge clock);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(negedge clock);
      end
      req_ch.valid     <= 1'b1;
      req_ch.dst_red   <= dst.red;
      req_ch.dst_green <= dst.green;
      req_ch.dst_blue  <= dst.blue;
      req_ch.dst_alpha <= dst.alpha;
      req_ch.src_red   <= src.red;
      req_ch.src_green <= src.green;
      req_ch.src_blue  <= src.blue;
      req_ch.src_alpha <= src.alpha;
      do @(posedge clock); while (!req_ch.ready);
      pending_pixels.push_back(blend_pixel(dst, src));
   endtask

   // stop requesting and wait for every pending result
   task automatic drain_pipe();
      @(negedge clock);
      req_ch.valid <= 1'b0;
      while (pending_pixels.size() != 0) @(posedge clock);
   endtask

   task automatic write_csr(input logic index, input logic [7:0] data);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= index;
      csr_wdata <= data;
      @(negedge clock);
      csr_we    <= 1'b0;
      if (index == CSR_BLEND_MODE) begin
         blend_mode_now = mode_type'(data[1:0]);
      end else begin
         factor_now = data;
      end
   endtask

   // idle the block, then load mode (junk in the upper bits) and factor
   task automatic set_blend(input mode_type mode, input chan_type factor);
      logic [7:0] data;
      drain_pipe();
      data      = 8'($urandom);
      data[1:0] = mode;
      write_csr(CSR_BLEND_MODE, data);
      write_csr(CSR_ADD_FACTOR, factor);
   endtask

   // over mode straight out of reset
   task automatic test_reset_config();
      send_pixel(32'h11223344, 32'hAABBCC00);
      send_pixel(32'h10203040, 32'hFFFFFFFF);
      send_pixel(32'hFFFFFFFF, 32'hF0F0F080);
      send_pixel(32'h00000000, 32'h00000000);
   endtask

   // early exits and saturation in the under, add and factor modes
   task automatic test_mode_corners();
      set_blend(MODE_UNDER, 8'd0);
      send_pixel(32'h123456FF, 32'hFFFFFFFF);
      send_pixel(32'hFFFFFF00, 32'h11223344);
      send_pixel(32'h80808080, 32'hFFFFFFFF);
      send_pixel(32'hFFFFFF01, 32'hFFFFFFFF);
      set_blend(MODE_ADD, 8'hA5);
      send_pixel(32'hC0C0C000, 32'h80808080);
      send_pixel(32'h40404040, 32'h102030FF);
      send_pixel(32'hC0C0C0C0, 32'h80808080);
      send_pixel(32'h01020304, 32'h05060708);
      set_blend(MODE_FACTOR, 8'd0);
      send_pixel(32'h55555500, 32'h20202020);
      send_pixel(32'h40608080, 32'hFFFFFFFF);
      send_pixel(32'hFF804020, 32'h30303040);
      set_blend(MODE_FACTOR, ChMax);
      send_pixel(32'hC0C0C0C0, 32'h80808080);
      send_pixel(32'h10203001, 32'h0A0B0C10);
      set_blend(MODE_FACTOR, 8'h80);
      send_pixel(32'hFFFFFFFF, 32'h40404040);
      send_pixel(32'h20406080, 32'h7F7F7F7F);
   endtask

   // random pixels over every idling phase and mode
   task automatic test_random_blends();
      int       send_phase[4];
      int       stall_phase[4];
      chan_type factor;
      send_phase  = '{0, 57, 0, 13};
      stall_phase = '{0, 0, 57, 13};
      for (int p = 0; p < 4; p++) begin
         for (int k = 0; k < 4; k++) begin
            case ($urandom_range(0, 3))
               0:       factor = 8'd0;
               1:       factor = ChMax;
               default: factor = chan_type'($urandom);
            endcase
            set_blend(mode_type'(k), factor);
            send_idle_pct = send_phase[p];
            stall_pct     = stall_phase[p];
            for (int n = 0; n < 37; n++) send_pixel(random_pixel(), random_pixel());
         end
      end
      send_idle_pct = 0;
      stall_pct     = 0;
   endtask

   // long receiver hold-off while requests keep coming
   task automatic test_output_backpressure();
      set_blend(MODE_FACTOR, chan_type'($urandom));
      @(posedge clock);
      stall_hold = 300;
      for (int n = 0; n < 40; n++) send_pixel(random_pixel(), random_pixel());
      drain_pipe();
   endtask

   // result channel ready, with random stalls and the hold-off
   always @(negedge clock) begin
      if (stall_hold > 0) begin
         rsp_ch.ready <= 1'b0;
         stall_hold = stall_hold - 1;
      end else begin
         rsp_ch.ready <= ($urandom_range(0, 99) >= stall_pct);
      end
   end

   // compare each result with the oldest pending pixel
   always @(posedge clock) begin : check_results
      pixel_type want;
      pixel_type got;
      quad_type  want_q;
      quad_type  got_q;
      string     lane_name[4];
      lane_name = '{"out_alpha", "out_blue", "out_green", "out_red"};
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         got = {rsp_ch.out_red, rsp_ch.out_green, rsp_ch.out_blue, rsp_ch.out_alpha};
         if (pending_pixels.size() == 0) begin
            $error("result %h with no request pending", got);
            error_count++;
         end else begin
            want   = pending_pixels.pop_front();
            want_q = want;
            got_q  = got;
            for (int i = 0; i < 4; i++) begin
               if (got_q[i] !== want_q[i]) begin
                  $error("%s expected %0d actual %0d", lane_name[i], want_q[i], got_q[i]);
                  error_count++;
               end
            end
         end
      end
   end

   // run limit
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("== FAIL ==");
         $finish;
      end
   end

   initial begin
      reset            = 1'b1;
      csr_we           = 1'b0;
      csr_index        = CSR_BLEND_MODE;
      csr_wdata        = '0;
      req_ch.valid     = 1'b0;
      req_ch.dst_red   = '0;
      req_ch.dst_green = '0;
      req_ch.dst_blue  = '0;
      req_ch.dst_alpha = '0;
      req_ch.src_red   = '0;
      req_ch.src_green = '0;
      req_ch.src_blue  = '0;
      req_ch.src_alpha = '0;
      rsp_ch.ready     = 1'b0;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_reset_config();
      test_mode_corners();
      test_random_blends();
      test_output_backpressure();

      drain_pipe();
      repeat (2 * PIPE_DEPTH) @(posedge clock);
      if (error_count == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule

// File: filelist.f
sv/abu_pkg.sv
sv/abu_if.sv
sv/abu_front.sv
sv/abu_lanes.sv
sv/rgba_alpha_blend_unit.sv
test/testbench.sv
